// ----- design/ldr_pkg.sv -----
// ============================================================================
// ldr_pkg
// Shared types and constants for the longest distinct run block.
// ============================================================================
package ldr_pkg;

   // Fixed field widths of the request and response beats.
   localparam int unsigned SYMBOL_W     = 8;
   localparam int unsigned SYMBOL_COUNT = 256;
   localparam int unsigned LEN_W        = 17;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   // One request beat: a byte and its end-of-string mark.
   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                end_of_string;
   } ldr_req_type;

   // One response beat: the longest run and the overflow flag.
   typedef struct packed {
      logic [LEN_W-1:0] longest_length;
      logic             too_long;
   } ldr_rsp_type;

endpackage

// ----- design/ldr_ram.sv -----
// ============================================================================
// ldr_ram
// Generic single-write, single-read RAM with a registered read port.
// A read of the address being written returns the old contents.
// ============================================================================
module ldr_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/ldr_rsp_fifo.sv -----
// ============================================================================
// ldr_rsp_fifo
// Two-entry response queue that separates the update stage from the consumer.
// ============================================================================
module ldr_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ldr_pkg::ldr_rsp_type push_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ldr_pkg::ldr_rsp_type rsp_data,
   output logic [1:0]          level
);
   import ldr_pkg::*;

   ldr_rsp_type entry_ff [2];
   logic        head_ff;
   logic        head_in;
   logic [1:0]  cnt_ff;
   logic [1:0]  cnt_in;
   logic        pop;
   logic        tail;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = entry_ff[head_ff];
   assign level     = cnt_ff;
   assign pop       = rsp_valid && rsp_ready;
   assign tail      = head_ff ^ cnt_ff[0];

   // Occupancy and read pointer.
   always_comb begin
      head_in = pop ? ~head_ff : head_ff;
      cnt_in  = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         head_ff <= head_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Payload storage; the caller only pushes when there is room.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail] <= push_data;
      end
   end

endmodule

// ----- design/longest_distinct_run_last_seen.sv -----
// ============================================================================
// longest_distinct_run_last_seen
// Longest run of distinct bytes in a framed string, last-seen-position method.
// ============================================================================
// The block takes one byte per cycle and gives one response beat for every
// end-marked byte: the length of the longest run without a repeated byte and
// a flag that is set when the string ran past MAX_STRING_LENGTH bytes (the
// excess bytes are dropped). The last position of each byte value sits in a
// RAM that is read when a byte is accepted and written in the next cycle in the
// update stage; a repeat in the next cycle is forwarded around the RAM, so
// there is no stall for it. Per-value valid bits and the window registers are
// cleared in the same cycle that the end byte is processed, so a new string
// may start directly behind it and no clearing pass is needed after reset. A
// response is offered once its end byte has passed the update stage and been
// written into a two-entry response queue, which lets input continue while
// results wait; input stalls only when that queue and the update stage
// together hold two results and no response beat leaves in that cycle.
// ============================================================================
module longest_distinct_run_last_seen #(
   parameter longint unsigned MAX_STRING_LENGTH = 65536,
   parameter int unsigned     ALPHABET_SIZE     = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ldr_pkg::ldr_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ldr_pkg::ldr_rsp_type rsp_data
);
   import ldr_pkg::*;

   localparam int unsigned SYM_DEPTH = (ALPHABET_SIZE < SYMBOL_COUNT) ?
                                       ALPHABET_SIZE : SYMBOL_COUNT;
   localparam int unsigned IDX_W = $clog2(SYM_DEPTH);
   localparam int unsigned POS_W = $clog2(MAX_STRING_LENGTH);
   localparam int unsigned CNT_W = $clog2(MAX_STRING_LENGTH + 1);
   localparam logic [CNT_W-1:0] POS_LIMIT = CNT_W'(MAX_STRING_LENGTH);

   // Folding of a byte onto the alphabet, a constant table.
   logic [IDX_W-1:0] fold_lut [SYMBOL_COUNT];
   for (genvar g = 0; g < SYMBOL_COUNT; g++) begin : g_fold
      assign fold_lut[g] = IDX_W'(g % ALPHABET_SIZE);
   end

   logic                 accept;
   logic [IDX_W-1:0]     req_idx;

   // Update stage registers.
   logic                 s1_valid_ff;
   logic [IDX_W-1:0]     s1_idx_ff;
   logic                 s1_end_ff;
   logic                 fwd_hit_ff;
   logic                 fwd_hit_in;
   logic [POS_W-1:0]     fwd_pos_ff;

   // Per-string state.
   logic [SYM_DEPTH-1:0] valid_ff;
   logic [SYM_DEPTH-1:0] valid_in;
   logic [POS_W-1:0]     win_ff;
   logic [POS_W-1:0]     win_in;
   logic [CNT_W-1:0]     cur_pos_ff;
   logic [CNT_W-1:0]     cur_pos_in;
   logic [CNT_W-1:0]     best_ff;
   logic [CNT_W-1:0]     best_in;
   logic                 ovf_ff;
   logic                 ovf_in;

   logic [POS_W-1:0]     ram_rd_data;
   logic [POS_W-1:0]     last_pos;
   logic                 pos_full;
   logic                 take;
   logic                 seen;
   logic [POS_W-1:0]     win_new;
   logic [CNT_W-1:0]     run;
   logic [CNT_W-1:0]     best_new;
   logic                 push;
   ldr_rsp_type          push_data;
   logic [1:0]           fifo_level;

   // Input handshake: room is needed for any result still in flight; a
   // response beat leaving in this cycle frees one place.
   assign req_ready = ((fifo_level + 2'(s1_valid_ff && s1_end_ff)) <
                       (2'd2 + 2'(rsp_valid && rsp_ready)));
   assign accept    = req_valid && req_ready;
   assign req_idx   = fold_lut[req_data.symbol];

   // Last-position store.
   ldr_ram #(
      .WIDTH (POS_W),
      .DEPTH (SYM_DEPTH)
   ) u_last_pos (
      .clock   (clock),
      .wr_en   (take),
      .wr_addr (s1_idx_ff),
      .wr_data (cur_pos_ff[POS_W-1:0]),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (ram_rd_data)
   );

   // A write in the same cycle as the read is forwarded to the next update.
   assign fwd_hit_in = accept && take && (req_idx == s1_idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff  <= req_idx;
         s1_end_ff  <= req_data.end_of_string;
         fwd_hit_ff <= fwd_hit_in;
         fwd_pos_ff <= cur_pos_ff[POS_W-1:0];
      end
   end

   // Update stage: move the window, record the position, track the best run.
   always_comb begin
      last_pos = fwd_hit_ff ? fwd_pos_ff : ram_rd_data;
      pos_full = (cur_pos_ff == POS_LIMIT);
      take     = s1_valid_ff && !pos_full;
      seen     = valid_ff[s1_idx_ff] && (last_pos >= win_ff);
      win_new  = seen ? (last_pos + POS_W'(1)) : win_ff;
      run      = cur_pos_ff - CNT_W'(win_new) + CNT_W'(1);
      best_new = (take && (run > best_ff)) ? run : best_ff;

      valid_in   = valid_ff;
      win_in     = win_ff;
      cur_pos_in = cur_pos_ff;
      best_in    = best_ff;
      ovf_in     = ovf_ff;
      if (s1_valid_ff) begin
         if (pos_full) begin
            ovf_in = 1'b1;
         end else begin
            valid_in[s1_idx_ff] = 1'b1;
            win_in              = win_new;
            cur_pos_in          = cur_pos_ff + CNT_W'(1);
            best_in             = best_new;
         end
         if (s1_end_ff) begin
            valid_in   = '0;
            win_in     = '0;
            cur_pos_in = '0;
            best_in    = '0;
            ovf_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         win_ff     <= '0;
         cur_pos_ff <= '0;
         best_ff    <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         win_ff     <= win_in;
         cur_pos_ff <= cur_pos_in;
         best_ff    <= best_in;
         ovf_ff     <= ovf_in;
      end
   end

   // Result of an end byte, saturated to the field width.
   always_comb begin
      push = s1_valid_ff && s1_end_ff;
      if (64'(best_new) > 64'(LEN_MAX)) begin
         push_data.longest_length = LEN_MAX;
         push_data.too_long       = 1'b1;
      end else begin
         push_data.longest_length = LEN_W'(best_new);
         push_data.too_long       = ovf_ff || pos_full;
      end
   end

   ldr_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .level     (fifo_level)
   );

   // Results in flight never exceed the queue depth.
   a_room: assert property (@(posedge clock) disable iff (reset)
      (fifo_level + 2'(s1_valid_ff && s1_end_ff)) <= 2'd2)
      else $error("response queue overrun");

   // The window never starts past the next position.
   a_window: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(win_ff) <= cur_pos_ff)
      else $error("window start beyond current position");

   // The best run never exceeds the bytes taken so far.
   a_best: assert property (@(posedge clock) disable iff (reset)
      best_ff <= cur_pos_ff)
      else $error("best length beyond string length");

   // The position count stays within the bound.
   a_bound: assert property (@(posedge clock) disable iff (reset)
      cur_pos_ff <= POS_LIMIT)
      else $error("position beyond bound");

   // An end byte leaves the per-string state cleared.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_end_ff) |=> (cur_pos_ff == '0 && valid_ff == '0 && !ovf_ff))
      else $error("string state not cleared after end byte");

endmodule
